### src/svn_pkg.sv
// Shared widths, codes and constants of the scaled vector norm unit.
package svn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;
    localparam int ACC_W     = 64;
    localparam int NUM_W     = IN_W + FRAC_BITS;
    localparam int RATIO_W   = IN_W - 1;
    localparam int PROD_W    = 2 * RATIO_W;
    localparam int ROOT_W    = ACC_W / 2;

    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    localparam logic [1:0] MODE_L1   = 2'd0;
    localparam logic [1:0] MODE_L2   = 2'd1;
    localparam logic [1:0] MODE_LINF = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_MODE   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SCALE = 2'd2;

endpackage

### src/scaled_vector_norm_unit.sv
// Scaled vector norm unit: sequencer, accumulator and result register.
//
// Requests carry one vector element and its scale (signed Q16.16) plus a last
// flag; in_ready is high while the sequencer waits for a request. Each element
// is divided by its scale in a bit-serial divider, squared in a bit-serial
// multiplier in L2 mode and folded into the running accumulator. The last
// element of an L2 vector also passes through the square-root unit. The last
// element loads norm_value and status into the result register, where they
// wait for out_ready, and clears the accumulator. Processing of the next
// request overlaps a waiting result; only a second finished result waits for
// the first to be taken.
// norm_mode is written through cfg_wr_en/cfg_wr_data. The user must write it
// only while the unit is idle; the unit itself does not enforce this.
// Reset empties the result register, clears the accumulator and the zero-scale
// flag, and sets norm_mode to L2.
module scaled_vector_norm_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [svn_pkg::IN_W-1:0]   element_value,
    input  logic signed [svn_pkg::IN_W-1:0]   scale_value,
    input  logic                              last_element,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [svn_pkg::OUT_W-1:0]         norm_value,
    output logic [1:0]                        status
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_SQRT,
        ST_FIN
    } state_t;

    state_t                          state_reg;
    logic [1:0]                      norm_mode_reg;
    logic [svn_pkg::ACC_W-1:0]       acc_reg;
    logic                            zero_seen_reg;
    logic                            last_reg;
    logic [svn_pkg::ACC_W-1:0]       addend_reg;
    logic                            out_valid_reg;
    logic [svn_pkg::OUT_W-1:0]       norm_reg;
    logic [1:0]                      status_reg;

    logic                            accept;
    logic [svn_pkg::IN_W-1:0]        elem_mag;
    logic [svn_pkg::IN_W-1:0]        scale_mag;
    logic [svn_pkg::NUM_W-1:0]       dividend;
    logic                            div_done;
    logic [svn_pkg::NUM_W-1:0]       quotient;
    logic [svn_pkg::RATIO_W-1:0]     ratio_sat;
    logic                            mul_start;
    logic                            mul_done;
    logic [svn_pkg::PROD_W-1:0]      product;
    logic                            sqrt_start;
    logic                            sqrt_done;
    logic [svn_pkg::ROOT_W-1:0]      root;
    logic [svn_pkg::ACC_W:0]         sum;
    logic [svn_pkg::ACC_W-1:0]       acc_next;
    logic [svn_pkg::OUT_W-1:0]       norm_next;
    logic [1:0]                      status_next;
    logic                            out_free;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        elem_mag  = element_value[svn_pkg::IN_W-1] ? (~element_value + 1'b1) : element_value;
        scale_mag = scale_value[svn_pkg::IN_W-1] ? (~scale_value + 1'b1) : scale_value;
        dividend  = {elem_mag, {svn_pkg::FRAC_BITS{1'b0}}};
        // A zero divisor yields an all-ones quotient, which saturates like any overflow.
        if (quotient > svn_pkg::NUM_W'(svn_pkg::RATIO_MAX))
        begin
            ratio_sat = svn_pkg::RATIO_MAX;
        end
        else
        begin
            ratio_sat = quotient[svn_pkg::RATIO_W-1:0];
        end
    end

    assign mul_start  = div_done && (norm_mode_reg == svn_pkg::MODE_L2);
    assign sqrt_start = (state_reg == ST_ACC) && last_reg && (norm_mode_reg == svn_pkg::MODE_L2);

    always_comb
    begin
        sum = {1'b0, acc_reg} + {1'b0, addend_reg};
        case (norm_mode_reg)
            svn_pkg::MODE_L1,
            svn_pkg::MODE_L2:
            begin
                acc_next = sum[svn_pkg::ACC_W] ? {svn_pkg::ACC_W{1'b1}} : sum[svn_pkg::ACC_W-1:0];
            end
            svn_pkg::MODE_LINF:
            begin
                acc_next = (addend_reg > acc_reg) ? addend_reg : acc_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        case (norm_mode_reg)
            svn_pkg::MODE_L2:
            begin
                norm_next = svn_pkg::OUT_W'(root);
            end
            svn_pkg::MODE_L1,
            svn_pkg::MODE_LINF:
            begin
                if (|acc_reg[svn_pkg::ACC_W-1:svn_pkg::OUT_W])
                begin
                    norm_next = {svn_pkg::OUT_W{1'b1}};
                end
                else
                begin
                    norm_next = acc_reg[svn_pkg::OUT_W-1:0];
                end
            end
            default:
            begin
                norm_next = '0;
            end
        endcase

        if (norm_mode_reg == svn_pkg::MODE_BAD)
        begin
            status_next = svn_pkg::STATUS_BAD_MODE;
        end
        else if (zero_seen_reg)
        begin
            status_next = svn_pkg::STATUS_ZERO_SCALE;
        end
        else
        begin
            status_next = svn_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            norm_mode_reg <= svn_pkg::MODE_L2;
            acc_reg       <= '0;
            zero_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                norm_mode_reg <= cfg_wr_data;
            end
            // Hold the result until the previous one has been taken.
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (scale_mag == '0)
                        begin
                            zero_seen_reg <= 1'b1;
                        end
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= (norm_mode_reg == svn_pkg::MODE_L2) ? ST_MUL : ST_ACC;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    acc_reg <= acc_next;
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (norm_mode_reg == svn_pkg::MODE_L2)
                    begin
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        acc_reg       <= '0;
                        zero_seen_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_element;
        end
        if (div_done)
        begin
            addend_reg <= svn_pkg::ACC_W'(ratio_sat);
        end
        if (mul_done)
        begin
            addend_reg <= svn_pkg::ACC_W'(product);
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            norm_reg   <= norm_next;
            status_reg <= status_next;
        end
    end

    svn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (dividend),
        .divisor  (scale_mag),
        .done     (div_done),
        .quotient (quotient)
    );

    svn_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (ratio_sat),
        .done    (mul_done),
        .product (product)
    );

    svn_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_next),
        .done     (sqrt_done),
        .root     (root)
    );

    assign out_valid  = out_valid_reg;
    assign norm_value = norm_reg;
    assign status     = status_reg;

endmodule

### src/svn_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module svn_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [svn_pkg::NUM_W-1:0]   dividend,
    input  logic [svn_pkg::IN_W-1:0]    divisor,
    output logic                        done,
    output logic [svn_pkg::NUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(svn_pkg::NUM_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [svn_pkg::IN_W-1:0]  rem_reg;
    logic [svn_pkg::IN_W-1:0]  dvs_reg;
    logic [svn_pkg::NUM_W-1:0] quo_reg;

    logic [svn_pkg::IN_W:0]    trial;
    logic [svn_pkg::IN_W:0]    diff;
    logic                      fits;
    logic [svn_pkg::IN_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[svn_pkg::NUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[svn_pkg::IN_W-1:0] : trial[svn_pkg::IN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(svn_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[svn_pkg::NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/svn_mul.sv
// Bit-serial shift-add squarer for the saturated ratio.
module svn_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [svn_pkg::RATIO_W-1:0]   operand,
    output logic                          done,
    output logic [svn_pkg::PROD_W-1:0]    product
);

    localparam int CNT_W = $clog2(svn_pkg::RATIO_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [svn_pkg::PROD_W-1:0]   mcand_reg;
    logic [svn_pkg::RATIO_W-1:0]  mplier_reg;
    logic [svn_pkg::PROD_W-1:0]   prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(svn_pkg::RATIO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= svn_pkg::PROD_W'(operand);
            mplier_reg <= operand;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[svn_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[svn_pkg::RATIO_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

### src/svn_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module svn_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [svn_pkg::ACC_W-1:0]    radicand,
    output logic                         done,
    output logic [svn_pkg::ROOT_W-1:0]   root
);

    localparam int CNT_W = $clog2(svn_pkg::ROOT_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [svn_pkg::ACC_W-1:0]   rad_reg;
    logic [svn_pkg::ACC_W-1:0]   res_reg;
    logic [svn_pkg::ACC_W-1:0]   bit_reg;

    logic [svn_pkg::ACC_W-1:0]   trial;
    logic                        fits;

    always_comb
    begin
        trial = res_reg + bit_reg;
        fits  = (rad_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(svn_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Leading steps with the test bit above the radicand leave the root at zero.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(svn_pkg::ACC_W - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rad_reg <= rad_reg - trial;
                res_reg <= {1'b0, res_reg[svn_pkg::ACC_W-1:1]} + bit_reg;
            end
            else
            begin
                res_reg <= {1'b0, res_reg[svn_pkg::ACC_W-1:1]};
            end
            bit_reg <= {2'b00, bit_reg[svn_pkg::ACC_W-1:2]};
        end
    end

    assign done = done_reg;
    assign root = res_reg[svn_pkg::ROOT_W-1:0];

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scaled vector norm unit.
module testbench;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 23;

    localparam logic [svn_pkg::OUT_W-1:0] NORM_CEIL = {svn_pkg::OUT_W{1'b1}};
    localparam logic [svn_pkg::IN_W-1:0]  Q_ONE     = 32'h0001_0000;

    typedef struct {
        logic [svn_pkg::IN_W-1:0] element;
        logic [svn_pkg::IN_W-1:0] scale;
        logic                     last;
    } elem_req_t;

    typedef struct {
        logic [svn_pkg::OUT_W-1:0] norm;
        logic [1:0]                status;
    } norm_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = svn_pkg::MODE_L2;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [svn_pkg::IN_W-1:0] element_value = '0;
    logic [svn_pkg::IN_W-1:0] scale_value = '0;
    logic last_element = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [svn_pkg::OUT_W-1:0] norm_value;
    logic [1:0] status;

    elem_req_t    pending_elems[$];
    norm_result_t expected_norms[$];

    logic [svn_pkg::ACC_W-1:0] acc_model = '0;
    logic                      zero_scale_flag = 1'b0;
    logic [1:0]                mode_setting = svn_pkg::MODE_L2;

    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 84;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    scaled_vector_norm_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .scale_value   (scale_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .norm_value    (norm_value),
        .status        (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [svn_pkg::ROOT_W-1:0] floor_root(
        input logic [svn_pkg::ACC_W-1:0] v);
        logic [svn_pkg::ACC_W-1:0] root;
        logic [svn_pkg::ACC_W-1:0] trial;
        int b;
        root = '0;
        for (b = svn_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[svn_pkg::ROOT_W-1:0];
    endfunction

    // Fold one accepted request into the model state; queue a result on last.
    function automatic void fold_element(input logic [svn_pkg::IN_W-1:0] elem,
                                         input logic [svn_pkg::IN_W-1:0] scale,
                                         input logic last);
        logic [svn_pkg::IN_W-1:0]    emag;
        logic [svn_pkg::IN_W-1:0]    smag;
        logic [svn_pkg::NUM_W-1:0]   quot;
        logic [svn_pkg::ACC_W-1:0]   ratio;
        logic [svn_pkg::ACC_W:0]     total;
        logic [svn_pkg::ACC_W-1:0]   full_norm;
        norm_result_t                res;
        emag = elem[svn_pkg::IN_W-1] ? (~elem + 1'b1) : elem;
        smag = scale[svn_pkg::IN_W-1] ? (~scale + 1'b1) : scale;
        if (smag == '0)
        begin
            ratio = svn_pkg::ACC_W'(svn_pkg::RATIO_MAX);
            zero_scale_flag = 1'b1;
        end
        else
        begin
            quot = {emag, {svn_pkg::FRAC_BITS{1'b0}}} / smag;
            ratio = (quot > svn_pkg::NUM_W'(svn_pkg::RATIO_MAX))
                    ? svn_pkg::ACC_W'(svn_pkg::RATIO_MAX) : svn_pkg::ACC_W'(quot);
        end

        total = {1'b0, acc_model};
        if (mode_setting == svn_pkg::MODE_L1)
            total = total + ratio;
        else if (mode_setting == svn_pkg::MODE_L2)
            total = total + ratio * ratio;
        else if (mode_setting == svn_pkg::MODE_LINF && ratio > acc_model)
            total = {1'b0, ratio};
        acc_model = total[svn_pkg::ACC_W] ? {svn_pkg::ACC_W{1'b1}}
                                          : total[svn_pkg::ACC_W-1:0];

        if (!last)
            return;

        if (mode_setting == svn_pkg::MODE_L2)
            full_norm = svn_pkg::ACC_W'(floor_root(acc_model));
        else if (mode_setting == svn_pkg::MODE_BAD)
            full_norm = '0;
        else
            full_norm = acc_model;
        res.norm = (full_norm > svn_pkg::ACC_W'(NORM_CEIL))
                   ? NORM_CEIL : full_norm[svn_pkg::OUT_W-1:0];
        if (mode_setting == svn_pkg::MODE_BAD)
            res.status = svn_pkg::STATUS_BAD_MODE;
        else if (zero_scale_flag)
            res.status = svn_pkg::STATUS_ZERO_SCALE;
        else
            res.status = svn_pkg::STATUS_OK;
        expected_norms.push_back(res);
        acc_model = '0;
        zero_scale_flag = 1'b0;
    endfunction

    function automatic logic [svn_pkg::IN_W-1:0] pick_word();
        logic [svn_pkg::IN_W-1:0] w;
        int unsigned kind;
        kind = $urandom_range(4);
        case (kind)
            0: w = $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0000_0001;
                    3: w = 32'hFFFF_FFFF;
                    default: w = Q_ONE;
                endcase
            end
            2: w = $urandom_range(32'h0003_FFFF);
            default: w = Q_ONE + $urandom_range(32'h0007_FFFF);
        endcase
        if (kind >= 2 && $urandom_range(1) == 1)
            w = -w;
        return w;
    endfunction

    task automatic queue_elem(input logic [svn_pkg::IN_W-1:0] elem,
                              input logic [svn_pkg::IN_W-1:0] scale,
                              input logic last);
        elem_req_t req;
        req.element = elem;
        req.scale = scale;
        req.last = last;
        pending_elems.push_back(req);
    endtask

    // Sample at the falling edge so the driver's updates have settled.
    task automatic wait_drained();
        while (pending_elems.size() != 0 || in_valid || expected_norms.size() != 0)
            @(negedge clk);
    endtask

    // Let a non-last request finish inside the unit before touching the mode.
    task automatic switch_mode(input logic [1:0] m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        mode_setting = m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Request driver
    always @(posedge clk)
    begin : request_driver
        elem_req_t req;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                fold_element(element_value, scale_value, last_element);
            if (!in_valid || in_ready)
            begin
                if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = pending_elems.pop_front();
                    in_valid <= 1'b1;
                    element_value <= req.element;
                    scale_value <= req.scale;
                    last_element <= req.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        norm_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_norms.size() == 0)
                    report_mismatch("norm_value with no result pending", 64'(norm_value), '0);
                else
                begin
                    want = expected_norms.pop_front();
                    if (norm_value !== want.norm)
                        report_mismatch("norm_value", 64'(norm_value), 64'(want.norm));
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0] mode_cycle [4];
        int regime;
        int phase;
        int count;
        int len;
        int i;
        logic partial;
        logic [svn_pkg::IN_W-1:0] scale;

        mode_cycle[0] = svn_pkg::MODE_L1;
        mode_cycle[1] = svn_pkg::MODE_L2;
        mode_cycle[2] = svn_pkg::MODE_LINF;
        mode_cycle[3] = svn_pkg::MODE_BAD;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // L2 straight out of reset: 3-4-5 triangle, saturated ratios, zero over zero
        queue_elem(32'h0003_0000, Q_ONE, 1'b0);
        queue_elem(32'hFFFC_0000, Q_ONE, 1'b1);
        queue_elem(32'h7FFF_FFFF, Q_ONE, 1'b0);
        queue_elem(32'h8000_0000, Q_ONE, 1'b1);
        queue_elem(32'h0000_0000, 32'h0000_0000, 1'b1);
        // sum of squares runs past 64 bits
        for (i = 0; i < 5; i++)
            queue_elem(32'h7FFF_FFFF, 32'h0000_0001, i == 4);

        switch_mode(svn_pkg::MODE_L1);
        queue_elem(32'h8000_0000, 32'h0000_0001, 1'b0);
        queue_elem(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_elem(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        queue_elem(32'h0001_8000, 32'hFFFF_0000, 1'b0);
        queue_elem(32'h0000_0000, Q_ONE, 1'b1);

        switch_mode(svn_pkg::MODE_LINF);
        queue_elem(32'h0002_0000, Q_ONE, 1'b0);
        queue_elem(32'hFFF9_0000, 32'h0002_0000, 1'b0);
        queue_elem(32'h0001_0000, Q_ONE, 1'b1);

        switch_mode(svn_pkg::MODE_BAD);
        queue_elem(32'h0005_0000, 32'h0000_0000, 1'b0);
        queue_elem(32'h0000_0001, Q_ONE, 1'b1);

        // mode flips from L1 to L2 in the middle of one vector
        switch_mode(svn_pkg::MODE_L1);
        queue_elem(32'h0002_0000, Q_ONE, 1'b0);
        switch_mode(svn_pkg::MODE_L2);
        queue_elem(32'h0003_0000, Q_ONE, 1'b0);
        queue_elem(32'h0004_0000, Q_ONE, 1'b1);

        for (regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 33 : (regime == 1) ? 84 : 0;
            recv_idle_pct = (regime == 0) ? 84 : (regime == 1) ? 33 : 0;
            for (phase = 0; phase < 8; phase++)
            begin
                switch_mode(mode_cycle[(phase + regime) % 4]);
                count = 0;
                while (count < PHASE_ITEMS)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(6, 1);
                    // leave a vector open so the next mode picks it up
                    partial = (count + len >= PHASE_ITEMS) && ($urandom_range(3) == 0);
                    for (i = 0; i < len; i++)
                    begin
                        scale = ($urandom_range(11) == 0) ? '0 : pick_word();
                        queue_elem(pick_word(), scale, (i == len - 1) && !partial);
                    end
                    count += len;
                end
            end
        end

        // close any vector still open
        switch_mode(svn_pkg::MODE_L1);
        queue_elem(pick_word(), Q_ONE, 1'b1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
